### rtl/core/salc_pkg.sv
// Shared constants and controller/datapath interface types for the cache lookup core.
package salc_pkg;

  localparam int DEF_NUM_SETS    = 2048;
  localparam int DEF_NUM_WAYS    = 16;
  localparam int DEF_OFFSET_BITS = 6;
  localparam int ADDR_W          = 64;
  localparam int EV_TAG_W        = 47;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctl_sts_t;

endpackage

### rtl/core/set_assoc_lru_cache_lookup_core.sv
// Top level of the set-associative LRU cache tag lookup core.
// Each request is handled in two steps: the set row is read from synchronous memory,
// then tags are compared, LRU ranks updated, the row written back and the result
// registered; that step waits while a pending result is stalled. No new request is
// accepted before then. After reset a clearing pass over the 2^floor(log2(NUM_SETS))
// set rows (2048 by default) zeroes valid bits and ranks; requests wait until it ends.
module set_assoc_lru_cache_lookup_core #(
  parameter int NUM_SETS    = salc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS    = salc_pkg::DEF_NUM_WAYS,
  parameter int OFFSET_BITS = salc_pkg::DEF_OFFSET_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [salc_pkg::ADDR_W-1:0]   in_byte_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_evicted,
  output logic [salc_pkg::EV_TAG_W-1:0] out_evicted_tag
);
  import salc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  salc_dp #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_byte_address (in_byte_address),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag)
  );

endmodule

### rtl/core/salc_ctrl.sv
// Controller state machine: clearing pass, request acceptance and result hand-off.
module salc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  salc_pkg::ctl_sts_t sts,
  output salc_pkg::ctl_cmd_t cmd
);
  import salc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_LOOK) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A new result can only come from a lookup that has just completed.
  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result raised without a completed lookup");

  // No result is pending while the tag store is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result valid during clearing pass");

  // An accepted request always moves to the compare and update step.
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_LOOK)
    else $error("accepted request did not reach lookup");

endmodule

### rtl/core/salc_dp.sv
// Datapath: set memories, tag compare, LRU rank update and result register.
module salc_dp #(
  parameter int NUM_SETS    = salc_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS    = salc_pkg::DEF_NUM_WAYS,
  parameter int OFFSET_BITS = salc_pkg::DEF_OFFSET_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  salc_pkg::ctl_cmd_t            cmd,
  output salc_pkg::ctl_sts_t            sts,
  input  logic [salc_pkg::ADDR_W-1:0]   in_byte_address,
  output logic                          out_hit,
  output logic                          out_evicted,
  output logic [salc_pkg::EV_TAG_W-1:0] out_evicted_tag
);
  import salc_pkg::*;

  localparam int SET_W  = $clog2(NUM_SETS + 1) - 1;
  localparam int DEPTH  = 1 << SET_W;
  localparam int TAG_W  = ADDR_W - OFFSET_BITS - SET_W;
  localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAY_W  = RANK_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);

  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_mem  [DEPTH];
  logic [NUM_WAYS-1:0]             vld_mem  [DEPTH];
  logic [NUM_WAYS-1:0][RANK_W-1:0] rank_mem [DEPTH];

  logic [SET_W-1:0]                clr_idx_r;
  logic [SET_W-1:0]                set_r;
  logic [TAG_W-1:0]                tag_r;
  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_row_r;
  logic [NUM_WAYS-1:0]             vld_row_r;
  logic [NUM_WAYS-1:0][RANK_W-1:0] rank_row_r;
  logic                            hit_r;
  logic                            evicted_r;
  logic [EV_TAG_W-1:0]             ev_tag_r;

  logic [NUM_WAYS-1:0]             hit_vec;
  logic                            hit;
  logic                            any_free;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                free_way;
  logic [WAY_W-1:0]                vict_way;
  logic [WAY_W-1:0]                sel_way;
  logic [RANK_W-1:0]               old_rank;
  logic                            fill;
  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_row_nxt;
  logic [NUM_WAYS-1:0]             vld_row_nxt;
  logic [NUM_WAYS-1:0][RANK_W-1:0] rank_row_nxt;
  logic [ADDR_W-1:0]               ev_wide;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    vict_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = vld_row_r[w] && (tag_row_r[w] == tag_r);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!vld_row_r[w]) begin
        free_way = WAY_W'(w);
      end
      if (vld_row_r[w] && (rank_row_r[w] == RANK_MAX)) begin
        vict_way = WAY_W'(w);
      end
    end
    hit      = |hit_vec;
    any_free = ~&vld_row_r;
    fill     = !hit && any_free;
    if (hit) begin
      sel_way  = hit_way;
      old_rank = rank_row_r[hit_way];
    end else if (any_free) begin
      sel_way  = free_way;
      old_rank = RANK_MAX;
    end else begin
      sel_way  = vict_way;
      old_rank = RANK_MAX;
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (sel_way == WAY_W'(w)) begin
        tag_row_nxt[w]  = tag_r;
        vld_row_nxt[w]  = 1'b1;
        rank_row_nxt[w] = '0;
      end else begin
        tag_row_nxt[w] = tag_row_r[w];
        vld_row_nxt[w] = vld_row_r[w];
        if (vld_row_r[w] && (fill || (rank_row_r[w] < old_rank))) begin
          rank_row_nxt[w] = rank_row_r[w] + RANK_W'(1);
        end else begin
          rank_row_nxt[w] = rank_row_r[w];
        end
      end
    end
    ev_wide = ADDR_W'(tag_row_r[vict_way]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear) begin
      clr_idx_r <= clr_idx_r + SET_W'(1);
    end
  end

  assign sts.clear_last = (clr_idx_r == SET_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vld_mem[clr_idx_r]  <= '0;
      rank_mem[clr_idx_r] <= '0;
    end else if (cmd.commit) begin
      tag_mem[set_r]  <= tag_row_nxt;
      vld_mem[set_r]  <= vld_row_nxt;
      rank_mem[set_r] <= rank_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r      <= in_byte_address[OFFSET_BITS +: SET_W];
      tag_r      <= in_byte_address[ADDR_W-1 -: TAG_W];
      tag_row_r  <= tag_mem[in_byte_address[OFFSET_BITS +: SET_W]];
      vld_row_r  <= vld_mem[in_byte_address[OFFSET_BITS +: SET_W]];
      rank_row_r <= rank_mem[in_byte_address[OFFSET_BITS +: SET_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= hit;
      evicted_r <= !hit && !any_free;
      ev_tag_r  <= (!hit && !any_free) ? ev_wide[EV_TAG_W-1:0] : '0;
    end
  end

  assign out_hit         = hit_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_tag = ev_tag_r;

endmodule
